@@ rtl/iqm_pkg.sv @@
package iqm_pkg;

   localparam int SAMPLE_W     = 16;
   localparam int COUNT_W      = 6;
   // n/4 is taken as a right shift
   localparam int QUARTER_SHIFT = 2;

   typedef enum logic [7:0] {
      S_IDLE = 8'b0000_0001,
      S_RDI  = 8'b0000_0010,
      S_GETI = 8'b0000_0100,
      S_CMP  = 8'b0000_1000,
      S_ACC  = 8'b0001_0000,
      S_DIV  = 8'b0010_0000,
      S_WAIT = 8'b0100_0000,
      S_DONE = 8'b1000_0000
   } iqm_state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } iqm_div_stat_type;

endpackage

@@ rtl/interquartile_mean_filter_core.sv @@
// Words are taken one per cycle while idle and written to the sample store until it is full.
// A last word starts the sort-free rank pass: one comparator checks every kept
// sample against every other, then a restoring divider forms the mean.
// The result is registered on leaving S_DONE, which waits until the previous result
// is taken; input reopens in the same cycle that the result turns valid.
// Synchronous active-high reset empties the batch, clears the mode and the output valid.
module interquartile_mean_filter_core import iqm_pkg::*; #(
   parameter int MAX_SAMPLES = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [SAMPLE_W-1:0] req_sample,
   input  logic                req_is_last,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [SAMPLE_W-1:0] rsp_mean,
   output logic [COUNT_W-1:0]  rsp_sample_count,
   output logic                rsp_overflowed,
   input  logic                csr_wr_en,
   input  logic                csr_wr_data
);

   localparam int AW   = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
   localparam int CW   = $clog2(MAX_SAMPLES + 1);
   localparam int DW   = SAMPLE_W + CW;
   localparam int ACCW = DW + 1;

   iqm_state_type state_ff, state_in;

   logic [SAMPLE_W-1:0] store_mem [MAX_SAMPLES];
   logic [SAMPLE_W-1:0] mem_q_ff;
   logic [AW-1:0]       rd_addr;
   logic                store_wr;

   logic [CW-1:0]       fill_count_ff, fill_count_in;
   logic                overflow_ff, overflow_in;
   logic                mode_ff;
   logic [CW-1:0]       i_ff, i_in;
   logic [CW-1:0]       j_ff, j_in;
   logic [CW-1:0]       rank_ff, rank_in;
   logic [SAMPLE_W-1:0] val_i_ff, val_i_in;
   logic [ACCW-1:0]     acc_ff, acc_in;
   logic [SAMPLE_W-1:0] mean_ff, mean_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_W-1:0] rsp_mean_ff, rsp_mean_in;
   logic [COUNT_W-1:0]  rsp_count_ff, rsp_count_in;
   logic                rsp_ovf_ff, rsp_ovf_in;

   logic                accept;
   logic                full;
   logic [CW-1:0]       next_j;
   logic [CW-1:0]       last_idx;
   logic [CW-1:0]       lo, hi, cnt;
   logic [SAMPLE_W-1:0] key_i, key_j;
   logic                ranks_below;
   logic                in_range;
   logic [ACCW-1:0]     val_ext;
   logic [ACCW-1:0]     mag_full;
   logic [DW-1:0]       quo;
   logic [DW-1:0]       quo_signed;
   logic                div_start;
   iqm_div_stat_type    div_stat;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid & req_ready;
   assign full      = (fill_count_ff == CW'(MAX_SAMPLES));
   assign store_wr  = accept & ~full;

   assign next_j   = j_ff + CW'(1);
   assign last_idx = fill_count_ff - CW'(1);
   assign lo       = fill_count_ff >> QUARTER_SHIFT;
   assign hi       = fill_count_ff - lo;
   assign cnt      = hi - lo;

   // flipping the sign bit makes signed order match unsigned order
   assign key_i = val_i_ff ^ {mode_ff, {(SAMPLE_W-1){1'b0}}};
   assign key_j = mem_q_ff ^ {mode_ff, {(SAMPLE_W-1){1'b0}}};
   // stable rank: equal keys order by store position
   assign ranks_below = (key_j < key_i) || ((key_j == key_i) && (j_ff < i_ff));
   assign in_range    = (rank_ff >= lo) && (rank_ff < hi);

   assign val_ext  = mode_ff ? {{(ACCW-SAMPLE_W){val_i_ff[SAMPLE_W-1]}}, val_i_ff}
                             : {{(ACCW-SAMPLE_W){1'b0}}, val_i_ff};
   assign mag_full = acc_ff[ACCW-1] ? (~acc_ff + ACCW'(1)) : acc_ff;
   assign quo_signed = acc_ff[ACCW-1] ? (~quo + DW'(1)) : quo;
   assign div_start  = (state_ff == S_DIV);

   always_comb begin
      unique case (state_ff)
         S_RDI:   rd_addr = i_ff[AW-1:0];
         S_CMP:   rd_addr = next_j[AW-1:0];
         default: rd_addr = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (store_wr) begin
         store_mem[fill_count_ff[AW-1:0]] <= req_sample;
      end
      mem_q_ff <= store_mem[rd_addr];
   end

   iqm_divider #(
      .DIVIDEND_W (DW),
      .DIVISOR_W  (CW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (mag_full[DW-1:0]),
      .divisor  (cnt),
      .quotient (quo),
      .stat     (div_stat)
   );

   always_comb begin
      state_in      = state_ff;
      fill_count_in = fill_count_ff;
      overflow_in   = overflow_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      rank_in       = rank_ff;
      val_i_in      = val_i_ff;
      acc_in        = acc_ff;
      mean_in       = mean_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_ready;
      rsp_mean_in   = rsp_mean_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_ovf_in    = rsp_ovf_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (full) begin
                  overflow_in = 1'b1;
               end else begin
                  fill_count_in = fill_count_ff + CW'(1);
               end
               if (req_is_last) begin
                  i_in     = '0;
                  acc_in   = '0;
                  state_in = S_RDI;
               end
            end
         end
         S_RDI: begin
            state_in = S_GETI;
         end
         S_GETI: begin
            val_i_in = mem_q_ff;
            j_in     = '0;
            rank_in  = '0;
            state_in = S_CMP;
         end
         S_CMP: begin
            if (ranks_below) begin
               rank_in = rank_ff + CW'(1);
            end
            j_in = next_j;
            if (j_ff == last_idx) begin
               state_in = S_ACC;
            end
         end
         S_ACC: begin
            if (in_range) begin
               acc_in = acc_ff + val_ext;
            end
            if (i_ff == last_idx) begin
               state_in = S_DIV;
            end else begin
               i_in     = i_ff + CW'(1);
               state_in = S_RDI;
            end
         end
         S_DIV: begin
            state_in = S_WAIT;
         end
         S_WAIT: begin
            if (div_stat.done) begin
               mean_in  = quo_signed[SAMPLE_W-1:0];
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_mean_in   = mean_ff;
               rsp_count_in  = COUNT_W'(fill_count_ff);
               rsp_ovf_in    = overflow_ff;
               fill_count_in = '0;
               overflow_in   = 1'b0;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         fill_count_ff <= '0;
         overflow_ff   <= 1'b0;
         mode_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         fill_count_ff <= fill_count_in;
         overflow_ff   <= overflow_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_wr_en) begin
            mode_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      i_ff         <= i_in;
      j_ff         <= j_in;
      rank_ff      <= rank_in;
      val_i_ff     <= val_i_in;
      acc_ff       <= acc_in;
      mean_ff      <= mean_in;
      rsp_mean_ff  <= rsp_mean_in;
      rsp_count_ff <= rsp_count_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_mean         = rsp_mean_ff;
   assign rsp_sample_count = rsp_count_ff;
   assign rsp_overflowed   = rsp_ovf_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_count_ff <= CW'(MAX_SAMPLES))
      else $error("fill count beyond store depth");

   a_last_starts: assert property (@(posedge clock) disable iff (reset)
      accept && req_is_last |=> state_ff == S_RDI)
      else $error("last word did not start the rank pass");

   a_rank_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CMP |-> rank_ff <= j_ff)
      else $error("rank exceeds compares done");

   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> state_ff == S_WAIT)
      else $error("divider finished outside wait");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_DONE)
      else $error("response raised outside done");

endmodule

@@ rtl/iqm_divider.sv @@
module iqm_divider import iqm_pkg::*; #(
   parameter int DIVIDEND_W = 22,
   parameter int DIVISOR_W  = 6
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic [DIVIDEND_W-1:0] quotient,
   output iqm_div_stat_type      stat
);

   localparam int STEP_W = $clog2(DIVIDEND_W + 1);

   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  dvs_ff;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;

   logic [DIVISOR_W:0]    rem_shift;
   logic [DIVISOR_W:0]    diff;
   logic                  fits;

   // restoring division, one quotient bit a cycle
   assign rem_shift = {rem_ff, quo_ff[DIVIDEND_W-1]};
   assign diff      = rem_shift - {1'b0, dvs_ff};
   assign fits      = rem_shift >= {1'b0, dvs_ff};

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in  = {quo_ff[DIVIDEND_W-2:0], fits};
         rem_in  = fits ? diff[DIVISOR_W-1:0] : rem_shift[DIVISOR_W-1:0];
         step_in = step_ff + STEP_W'(1);
         if (step_ff == STEP_W'(DIVIDEND_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      if (start) begin
         dvs_ff <= divisor;
      end
   end

   assign quotient  = quo_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

@@ verif/tb_interquartile_mean_filter_core.sv @@
`timescale 1ns / 100ps

module tb_interquartile_mean_filter_core;
   import iqm_pkg::*;

   localparam int MAX_KEEP = 32;
   // room for the longest batch to go from last word to result
   localparam int END_SETTLE = 1200;
   localparam int CSR_SETTLE = 8;
   localparam int HOLD_OFF = 2500;
   // watchdog limit, several times what a normal run needs
   localparam int CYCLE_LIMIT = 600_000;

   typedef struct {
      logic [SAMPLE_W-1:0] mean;
      logic [COUNT_W-1:0]  count;
      logic                overflowed;
   } batch_result_t;

   class batch_mean_board;
      logic [SAMPLE_W-1:0] store [MAX_KEEP];
      int                  fill;
      bit                  dropped;
      bit                  signed_mode;
      int                  failures;
      batch_result_t       expected_q [$];

      function new();
         fill = 0;
         dropped = 0;
         signed_mode = 0;
         failures = 0;
      endfunction

      // flipping the top bit makes signed order match unsigned order
      function logic [SAMPLE_W-1:0] rank_key(logic [SAMPLE_W-1:0] v);
         return signed_mode ? {~v[SAMPLE_W-1], v[SAMPLE_W-2:0]} : v;
      endfunction

      function logic [SAMPLE_W-1:0] iq_mean();
         logic [SAMPLE_W-1:0] ranked [MAX_KEEP];
         logic [SAMPLE_W-1:0] v;
         longint              sum;
         longint              quot;
         int                  lo;
         int                  hi;
         int                  j;
         for (int i = 0; i < fill; i++) ranked[i] = store[i];
         for (int i = 1; i < fill; i++) begin
            v = ranked[i];
            j = i;
            while (j > 0 && rank_key(ranked[j-1]) > rank_key(v)) begin
               ranked[j] = ranked[j-1];
               j--;
            end
            ranked[j] = v;
         end
         lo = fill >> QUARTER_SHIFT;
         hi = fill - lo;
         sum = 0;
         for (int i = lo; i < hi; i++)
            sum += signed_mode ? longint'($signed(ranked[i])) : longint'(ranked[i]);
         // longint division truncates toward zero
         quot = sum / longint'(hi - lo);
         return quot[SAMPLE_W-1:0];
      endfunction

      function void note_word(logic [SAMPLE_W-1:0] s, logic last);
         batch_result_t r;
         if (fill < MAX_KEEP) begin
            store[fill] = s;
            fill++;
         end else begin
            dropped = 1;
         end
         if (last) begin
            r.mean = iq_mean();
            r.count = COUNT_W'(fill);
            r.overflowed = dropped;
            expected_q.push_back(r);
            fill = 0;
            dropped = 0;
         end
      endfunction

      function void check_result(logic [SAMPLE_W-1:0] mean, logic [COUNT_W-1:0] count,
                                 logic overflowed);
         batch_result_t e;
         if (expected_q.size() == 0) begin
            failures++;
            $error("unexpected result word: mean %h, sample_count %0d", mean, count);
            return;
         end
         e = expected_q.pop_front();
         if (mean !== e.mean) begin
            failures++;
            $error("mean: expected %h, actual %h", e.mean, mean);
         end
         if (count !== e.count) begin
            failures++;
            $error("sample_count: expected %0d, actual %0d", e.count, count);
         end
         if (overflowed !== e.overflowed) begin
            failures++;
            $error("overflowed: expected %b, actual %b", e.overflowed, overflowed);
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic [SAMPLE_W-1:0] req_sample;
   logic                req_is_last;
   logic                rsp_valid;
   logic                rsp_ready;
   logic [SAMPLE_W-1:0] rsp_mean;
   logic [COUNT_W-1:0]  rsp_sample_count;
   logic                rsp_overflowed;
   logic                csr_wr_en;
   logic                csr_wr_data;

   batch_mean_board board = new();
   int tx_idle_pct = 0;
   int rx_idle_pct = 0;
   int hold_left = 0;
   int words_sent = 0;
   int cycle_count = 0;

   interquartile_mean_filter_core #(
      .MAX_SAMPLES(MAX_KEEP)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_sample(req_sample),
      .req_is_last(req_is_last),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_mean(rsp_mean),
      .rsp_sample_count(rsp_sample_count),
      .rsp_overflowed(rsp_overflowed),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   initial clock = 1'b0;
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // result side: check accepted words, then pick next ready
   initial begin
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready)
            board.check_result(rsp_mean, rsp_sample_count, rsp_overflowed);
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Verification failed");
      $finish;
   end

   task automatic sender_gap();
      if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   task automatic send_word(input logic [SAMPLE_W-1:0] s, input logic last);
      req_valid <= 1'b1;
      req_sample <= s;
      req_is_last <= last;
      do @(posedge clock); while (!req_ready);
      board.note_word(s, last);
      words_sent++;
      sender_gap();
   endtask

   task automatic wait_drain();
      if (board.pending() != 0) begin
         // the last word is already taken; stop offering it
         req_valid <= 1'b0;
         while (board.pending() != 0) @(posedge clock);
      end
   endtask

   task automatic set_mode(input bit m);
      wait_drain();
      req_valid <= 1'b0;
      repeat (CSR_SETTLE) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= m;
      @(posedge clock);
      board.signed_mode = m;
      csr_wr_en <= 1'b0;
   endtask

   function automatic logic [SAMPLE_W-1:0] pick_sample(input logic [SAMPLE_W-1:0] prev);
      case ($urandom_range(9))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return 16'h8000;
         3: return 16'h7FFF;
         4, 5: return prev;   // ties for the rank pass
         6: return SAMPLE_W'($urandom_range(15));
         7: return 16'hFFF0 | SAMPLE_W'($urandom_range(15));
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   task automatic send_batch(input int len, input int flip_at);
      logic [SAMPLE_W-1:0] s;
      s = SAMPLE_W'($urandom);
      for (int i = 0; i < len; i++) begin
         if (i == flip_at) set_mode(~board.signed_mode);
         s = pick_sample(s);
         send_word(s, i == len - 1);
      end
   endtask

   task automatic run_phase(input int tx_pct, input int rx_pct, input int word_budget);
      int stop_at;
      int len;
      int flip_at;
      tx_idle_pct = tx_pct;
      rx_idle_pct = rx_pct;
      stop_at = words_sent + word_budget;
      // last word arrives on a full store and is dropped
      send_batch(MAX_KEEP + 1, -1);
      while (words_sent < stop_at) begin
         if ($urandom_range(9) == 0) set_mode(1'($urandom_range(1)));
         case ($urandom_range(9))
            0: len = $urandom_range(MAX_KEEP + 1, MAX_KEEP + 8);
            1, 2: len = $urandom_range(9, MAX_KEEP);
            default: len = $urandom_range(1, 8);
         endcase
         flip_at = ($urandom_range(19) == 0 && len > 1) ? $urandom_range(1, len - 1) : -1;
         send_batch(len, flip_at);
      end
      wait_drain();
   endtask

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_sample <= '0;
      req_is_last <= 1'b0;
      csr_wr_en <= 1'b0;
      csr_wr_data <= 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // unsigned mode straight out of reset
      send_word(16'hFFFF, 1'b1);
      send_word(16'h0000, 1'b0);
      send_word(16'hFFFF, 1'b0);
      send_word(16'h8000, 1'b0);
      send_word(16'h7FFF, 1'b1);
      send_word(16'h0005, 1'b0);
      send_word(16'h0005, 1'b0);
      send_word(16'h0005, 1'b1);
      set_mode(1'b1);
      send_word(16'h0000, 1'b0);
      send_word(16'hFFFF, 1'b0);
      send_word(16'h8000, 1'b0);
      send_word(16'h7FFF, 1'b1);
      send_word(16'h8000, 1'b1);
      // -3 / 2 rounds toward zero
      send_word(16'hFFFF, 1'b0);
      send_word(16'hFFFE, 1'b1);
      // mode flipped mid-batch: last word's mode rules
      send_word(16'h0001, 1'b0);
      send_word(16'hFFFF, 1'b0);
      send_word(16'h8000, 1'b0);
      set_mode(1'b0);
      send_word(16'h7FFF, 1'b1);
      wait_drain();

      run_phase(14, 79, 650);

      // stall the result side long enough to back up the input
      hold_left = HOLD_OFF;
      repeat (6) send_batch($urandom_range(2, 6), -1);
      wait_drain();

      run_phase(79, 14, 650);
      run_phase(0, 0, 650);

      wait_drain();
      req_valid <= 1'b0;
      repeat (END_SETTLE) @(posedge clock);
      if (board.failures == 0 && board.pending() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
